// ===== src/rpcc_pkg.sv =====
// package for the response packet crc checker
// holds crc constants, status codes and the byte-wise crc function; no dependencies
`timescale 1ns / 1ps

package rpcc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'h8005;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd84;
  localparam logic [7:0]  MIN_COUNT     = 8'd4;
  localparam logic [7:0]  DEV_ERR_LEN   = 8'd1;
  localparam logic [7:0]  CRC_BYTES     = 8'd3;

  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_MAX_LEN = 2'd0;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_SHORT    = 3'd1,
    STATUS_LONG     = 3'd2,
    STATUS_CRC_ERR  = 3'd3,
    STATUS_DEV_ERR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LEN_GOOD  = 2'd0,
    LEN_SHORT = 2'd1,
    LEN_LONG  = 2'd2
  } len_fault_t;

  // eight bit steps, data lsb first, register shifts toward its msb
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = data[k] ^ crc[15];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ===== src/response_packet_crc_checker_unit.sv =====
// response packet crc checker: count byte, crc-16 over the body, status on the last byte
// depends on rpcc_pkg for constants, status codes and the crc function
// each accepted byte's result is registered in the output register
// throughput: one request per cycle unless out_valid is held with out_ready low
// the byte-wise crc update is unrolled into combinational xor logic
// reset: synchronous active-low rst_n clears packet state and output valid, max length to 84
`timescale 1ns / 1ps

module response_packet_crc_checker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_payload_valid,
  output logic                          out_packet_done,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_payload_len,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpcc_pkg::APB_AW-1:0]   paddr,
  input  logic [rpcc_pkg::APB_DW-1:0]   pwdata,
  output logic [rpcc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  import rpcc_pkg::*;

  logic [7:0]  max_len_r;
  logic [7:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  packet_count_r, packet_count_nxt;
  logic [15:0] crc_accum_r, crc_accum_nxt;
  logic [7:0]  rx_crc_low_r, rx_crc_low_nxt;
  len_fault_t  bad_length_r, bad_length_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_pvalid_r, out_pvalid_nxt;
  logic        out_done_r, out_done_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [7:0]  out_plen_r, out_plen_nxt;

  logic        in_acc;
  logic [8:0]  idx_p1, idx_p2, cnt_ext;
  logic [15:0] crc_step;
  logic [7:0]  plen;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_LEN) ? {{(APB_DW-8){1'b0}}, max_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_LEN)) begin
      max_len_r <= pwdata[7:0];
    end
  end

  assign idx_p1   = {1'b0, byte_index_r} + 9'd1;
  assign idx_p2   = {1'b0, byte_index_r} + 9'd2;
  assign cnt_ext  = {1'b0, packet_count_r};
  assign crc_step = crc_byte((byte_index_r == 8'd0) ? 16'h0000 : crc_accum_r, in_rx_byte);
  assign plen     = packet_count_r - CRC_BYTES;

  always_comb begin
    byte_index_nxt   = byte_index_r;
    packet_count_nxt = packet_count_r;
    crc_accum_nxt    = crc_accum_r;
    rx_crc_low_nxt   = rx_crc_low_r;
    bad_length_nxt   = bad_length_r;
    out_pvalid_nxt   = 1'b0;
    out_done_nxt     = 1'b0;
    out_status_nxt   = STATUS_OK;
    out_plen_nxt     = 8'd0;
    priority if (byte_index_r == 8'd0) begin
      packet_count_nxt = in_rx_byte;
      crc_accum_nxt    = crc_step;
      rx_crc_low_nxt   = 8'd0;
      priority if (in_rx_byte < MIN_COUNT) begin
        bad_length_nxt = LEN_SHORT;
      end else if (in_rx_byte > max_len_r) begin
        bad_length_nxt = LEN_LONG;
      end else begin
        bad_length_nxt = LEN_GOOD;
      end
      byte_index_nxt = 8'd1;
    end else if (bad_length_r != LEN_GOOD) begin
      if (byte_index_r >= 8'd3) begin
        out_done_nxt   = 1'b1;
        out_status_nxt = (bad_length_r == LEN_SHORT) ? STATUS_SHORT : STATUS_LONG;
        byte_index_nxt = 8'd0;
      end else begin
        byte_index_nxt = idx_p1[7:0];
      end
    end else if (idx_p1 >= cnt_ext) begin
      // last byte carries the received crc high byte
      out_done_nxt   = 1'b1;
      byte_index_nxt = 8'd0;
      if ({in_rx_byte, rx_crc_low_r} != crc_accum_r) begin
        out_status_nxt = STATUS_CRC_ERR;
      end else begin
        out_plen_nxt   = plen;
        out_status_nxt = (plen == DEV_ERR_LEN) ? STATUS_DEV_ERR : STATUS_OK;
      end
    end else begin
      if (idx_p2 == cnt_ext) begin
        rx_crc_low_nxt = in_rx_byte;
      end else begin
        crc_accum_nxt  = crc_step;
        out_pvalid_nxt = 1'b1;
      end
      byte_index_nxt = idx_p1[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= 8'd0;
      packet_count_r <= 8'd0;
      crc_accum_r    <= 16'h0000;
      rx_crc_low_r   <= 8'd0;
      bad_length_r   <= LEN_GOOD;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_index_r   <= byte_index_nxt;
        packet_count_r <= packet_count_nxt;
        crc_accum_r    <= crc_accum_nxt;
        rx_crc_low_r   <= rx_crc_low_nxt;
        bad_length_r   <= bad_length_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_r   <= in_rx_byte;
      out_pvalid_r <= out_pvalid_nxt;
      out_done_r   <= out_done_nxt;
      out_status_r <= out_status_nxt;
      out_plen_r   <= out_plen_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_payload_valid = out_pvalid_r;
  assign out_packet_done   = out_done_r;
  assign out_status        = out_status_r;
  assign out_payload_len   = out_plen_r;

endmodule
